// File: sv/pcrl_pkg.sv
// ----------------------------------------------------------------------------
// pcrl_pkg
// Shared types, constants and codes of the per-client request rate limiter.
// ----------------------------------------------------------------------------
package pcrl_pkg;

    // Field widths.
    localparam int TIME_W   = 32;
    localparam int KEY_W    = 32;
    localparam int COUNT_W  = 16;
    localparam int VERDICT_W = 2;

    // Default table depth.
    localparam int DEFAULT_TABLE_ENTRIES = 256;

    // Saturation value of the per-client counters.
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // A slot idle for longer than this many seconds is freed by a sweep.
    localparam logic [COUNT_W-1:0] IDLE_EXPIRY_SECONDS = 16'd300;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_LIMIT_ENABLE   = 2'd0,
        CFG_REQUESTS_PER_SECOND = 2'd1,
        CFG_BURST_LIMIT         = 2'd2,
        CFG_SWEEP_INTERVAL      = 2'd3
    } cfg_index_t;

    // Configuration reset values.
    localparam logic               RST_RATE_LIMIT_ENABLE = 1'b1;
    localparam logic [COUNT_W-1:0] RST_REQUESTS_PER_SECOND = 16'd10;
    localparam logic [COUNT_W-1:0] RST_BURST_LIMIT = 16'd20;
    localparam logic [COUNT_W-1:0] RST_SWEEP_INTERVAL = 16'd60;

    // Verdict codes.
    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_ALLOW      = 2'd0,
        VERDICT_OVER_RATE  = 2'd1,
        VERDICT_TABLE_FULL = 2'd2
    } verdict_t;

    // One table slot as stored in the slot memory.
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] window_count;
        logic [COUNT_W-1:0] burst_tally;
        logic [TIME_W-1:0]  open_time;
        logic [TIME_W-1:0]  last_seen;
    } slot_rec_t;

    // Flags of the shared compare unit.
    typedef struct packed {
        logic ge;
        logic gt;
        logic eq;
    } cmp_res_t;

endpackage

// File: sv/per_client_request_rate_limiter.sv
// With limiting disabled a taken word goes straight to the hand-off state S_DONE; with
// limiting enabled it first passes the sweep check and the table search, which ends
// early when the client is found. A due expiry sweep scans every slot first. One word
// is in work at a time, the next is taken once the result is loaded, and a held result
// word stalls the hand-off. Reset is synchronous, active low; afterwards a clearing pass
// marks all slots free, and no word is accepted until it ends.
// ----------------------------------------------------------------------------
// per_client_request_rate_limiter
// Fixed one-second window rate limiter with burst credit, per client address.
// A small sequencer scans a slot memory through one shared compare unit.
// ----------------------------------------------------------------------------
module per_client_request_rate_limiter #(
    parameter int TABLE_ENTRIES = pcrl_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [pcrl_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [pcrl_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // Request stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [63:0]                       s_tdata,   // client_addr, now_seconds
    // Verdict stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [39:0]                       m_tdata    // verdict, window_requests,
                                                         // burst_used, zero fill
);
    import pcrl_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] N_CNT    = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES - 1);
    localparam int REC_W = $bits(slot_rec_t);
    localparam int OUT_USED_W = VERDICT_W + 2 * COUNT_W;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_DUE    = 11'b00000000100,
        S_SWEEP  = 11'b00000001000,
        S_SEARCH = 11'b00000010000,
        S_WIN    = 11'b00000100000,
        S_RATE   = 11'b00001000000,
        S_BURST  = 11'b00010000000,
        S_INC    = 11'b00100000000,
        S_WRITE  = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } state_t;

    // Control registers.
    state_t             state_reg, state_next;
    logic               cfg_en_reg;
    logic [COUNT_W-1:0] rps_reg;
    logic [COUNT_W-1:0] burst_lim_reg;
    logic [COUNT_W-1:0] sweep_int_reg;
    logic [TIME_W-1:0]  last_sweep_reg, last_sweep_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               spare_found_reg, spare_found_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // Payload registers.
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]   spare_idx_reg, spare_idx_next;
    logic [IDX_W-1:0]   slot_idx_reg, slot_idx_next;
    logic [COUNT_W-1:0] win_cnt_reg, win_cnt_next;
    logic [COUNT_W-1:0] burst_reg, burst_next;
    logic [TIME_W-1:0]  win_start_reg, win_start_next;
    logic [TIME_W-1:0]  last_seen_reg, last_seen_next;
    verdict_t           verdict_reg, verdict_next;
    logic [COUNT_W-1:0] res_win_reg, res_win_next;
    logic [COUNT_W-1:0] res_burst_reg, res_burst_next;
    logic [39:0]        m_tdata_reg, m_tdata_next;

    // Memory and compare unit connections.
    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_addr;
    logic [REC_W-1:0]   mem_rd_data;
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    slot_rec_t          mem_wr_rec;
    slot_rec_t          rec_rd;
    slot_rec_t          rec_expired;
    logic [TIME_W-1:0]  cmp_a;
    logic [TIME_W-1:0]  cmp_b;
    logic [COUNT_W-1:0] cmp_c;
    cmp_res_t           cmp_res;
    logic               scan_issue;
    logic               in_accept;

    assign rec_rd    = slot_rec_t'(mem_rd_data);
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid & s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // A scan issues one read a cycle until every slot has been requested.
    assign scan_issue = (idx_reg != N_CNT);

    always_comb begin
        rec_expired       = rec_rd;
        rec_expired.valid = 1'b0;
    end

    pcrl_slot_mem #(
        .DEPTH  (TABLE_ENTRIES),
        .WIDTH  (REC_W),
        .ADDR_W (IDX_W)
    ) u_slot_mem (
        .aclk    (aclk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (REC_W'(mem_wr_rec))
    );

    pcrl_cmp u_cmp (
        .op_a (cmp_a),
        .op_b (cmp_b),
        .op_c (cmp_c),
        .res  (cmp_res)
    );

    // Operand selection for the shared compare unit.
    always_comb begin
        cmp_a = '0;
        cmp_b = '0;
        cmp_c = '0;
        case (state_reg)
            S_DUE: begin
                cmp_a = now_reg;
                cmp_b = last_sweep_reg;
                cmp_c = sweep_int_reg;
            end
            S_SWEEP: begin
                cmp_a = now_reg;
                cmp_b = rec_rd.last_seen;
                cmp_c = IDLE_EXPIRY_SECONDS;
            end
            S_SEARCH: begin
                cmp_a = key_reg;
                cmp_b = rec_rd.key;
            end
            S_WIN: begin
                cmp_a = now_reg;
                cmp_b = win_start_reg;
            end
            S_RATE: begin
                cmp_a = TIME_W'(win_cnt_reg);
                cmp_b = TIME_W'(rps_reg);
            end
            S_BURST: begin
                cmp_a = TIME_W'(burst_reg);
                cmp_b = TIME_W'(burst_lim_reg);
            end
            default: begin
                cmp_a = '0;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        state_next       = state_reg;
        last_sweep_next  = last_sweep_reg;
        idx_next         = idx_reg;
        rd_pend_next     = 1'b0;
        spare_found_next = spare_found_reg;
        m_tvalid_next    = m_tvalid_reg;
        key_next         = key_reg;
        now_next         = now_reg;
        rd_idx_next      = rd_idx_reg;
        spare_idx_next   = spare_idx_reg;
        slot_idx_next    = slot_idx_reg;
        win_cnt_next     = win_cnt_reg;
        burst_next       = burst_reg;
        win_start_next   = win_start_reg;
        last_seen_next   = last_seen_reg;
        verdict_next     = verdict_reg;
        res_win_next     = res_win_reg;
        res_burst_next   = res_burst_reg;
        m_tdata_next     = m_tdata_reg;
        mem_rd_en        = 1'b0;
        mem_rd_addr      = idx_reg[IDX_W-1:0];
        mem_wr_en        = 1'b0;
        mem_wr_addr      = idx_reg[IDX_W-1:0];
        mem_wr_rec       = '0;

        // The output word leaves on its handshake.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            // Mark every slot free after reset.
            S_CLEAR: begin
                mem_wr_en = 1'b1;
                if (idx_reg == LAST_CNT) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_IDLE: begin
                if (in_accept) begin
                    key_next = s_tdata[31:0];
                    now_next = s_tdata[63:32];
                    if (cfg_en_reg) begin
                        state_next = S_DUE;
                    end else begin
                        verdict_next   = VERDICT_ALLOW;
                        res_win_next   = '0;
                        res_burst_next = '0;
                        state_next     = S_DONE;
                    end
                end
            end

            // Sweep is due when now >= last sweep time + interval.
            S_DUE: begin
                idx_next         = '0;
                spare_found_next = 1'b0;
                if (cmp_res.ge) begin
                    last_sweep_next = now_reg;
                    state_next      = S_SWEEP;
                end else begin
                    state_next = S_SEARCH;
                end
            end

            // Read one slot a cycle; free it once its registered read data show it has expired.
            S_SWEEP: begin
                if (scan_issue) begin
                    mem_rd_en    = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_idx_next  = idx_reg[IDX_W-1:0];
                    idx_next     = idx_reg + 1'b1;
                end
                if (rd_pend_reg && rec_rd.valid && cmp_res.gt) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = rd_idx_reg;
                    mem_wr_rec  = rec_expired;
                end
                if (!scan_issue && !rd_pend_reg) begin
                    idx_next         = '0;
                    spare_found_next = 1'b0;
                    state_next       = S_SEARCH;
                end
            end

            // Look for the key and note the lowest free slot on the way.
            S_SEARCH: begin
                if (scan_issue) begin
                    mem_rd_en    = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_idx_next  = idx_reg[IDX_W-1:0];
                    idx_next     = idx_reg + 1'b1;
                end
                if (rd_pend_reg && rec_rd.valid && cmp_res.eq) begin
                    slot_idx_next  = rd_idx_reg;
                    win_cnt_next   = rec_rd.window_count;
                    burst_next     = rec_rd.burst_tally;
                    win_start_next = rec_rd.open_time;
                    last_seen_next = rec_rd.last_seen;
                    rd_pend_next   = 1'b0;
                    state_next     = S_WIN;
                end else begin
                    if (rd_pend_reg && !rec_rd.valid && !spare_found_reg) begin
                        spare_found_next = 1'b1;
                        spare_idx_next   = rd_idx_reg;
                    end
                    if (!scan_issue && !rd_pend_reg) begin
                        if (spare_found_reg) begin
                            slot_idx_next  = spare_idx_reg;
                            win_cnt_next   = '0;
                            burst_next     = '0;
                            win_start_next = now_reg;
                            last_seen_next = now_reg;
                            state_next     = S_WIN;
                        end else begin
                            verdict_next   = VERDICT_TABLE_FULL;
                            res_win_next   = '0;
                            res_burst_next = '0;
                            state_next     = S_DONE;
                        end
                    end
                end
            end

            // A later second opens a new window.
            S_WIN: begin
                if (cmp_res.gt) begin
                    win_cnt_next   = '0;
                    win_start_next = now_reg;
                end
                state_next = S_RATE;
            end

            S_RATE: begin
                state_next = cmp_res.ge ? S_BURST : S_INC;
            end

            // Over the rate: draw on burst credit or reject.
            S_BURST: begin
                if (cmp_res.ge) begin
                    verdict_next = VERDICT_OVER_RATE;
                    state_next   = S_WRITE;
                end else begin
                    if (burst_reg != COUNT_MAX) begin
                        burst_next = burst_reg + 1'b1;
                    end
                    state_next = S_INC;
                end
            end

            S_INC: begin
                if (win_cnt_reg != COUNT_MAX) begin
                    win_cnt_next = win_cnt_reg + 1'b1;
                end
                last_seen_next = now_reg;
                verdict_next   = VERDICT_ALLOW;
                state_next     = S_WRITE;
            end

            // Store the slot back and latch the result counts.
            S_WRITE: begin
                mem_wr_en               = 1'b1;
                mem_wr_addr             = slot_idx_reg;
                mem_wr_rec.valid        = 1'b1;
                mem_wr_rec.key          = key_reg;
                mem_wr_rec.window_count = win_cnt_reg;
                mem_wr_rec.burst_tally  = burst_reg;
                mem_wr_rec.open_time    = win_start_reg;
                mem_wr_rec.last_seen    = last_seen_reg;
                res_win_next            = win_cnt_reg;
                res_burst_next          = burst_reg;
                state_next              = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(40 - OUT_USED_W){1'b0}}, res_burst_reg,
                                     res_win_reg, verdict_reg};
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            last_sweep_reg  <= '0;
            idx_reg         <= '0;
            rd_pend_reg     <= 1'b0;
            spare_found_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            cfg_en_reg      <= RST_RATE_LIMIT_ENABLE;
            rps_reg         <= RST_REQUESTS_PER_SECOND;
            burst_lim_reg   <= RST_BURST_LIMIT;
            sweep_int_reg   <= RST_SWEEP_INTERVAL;
        end else begin
            state_reg       <= state_next;
            last_sweep_reg  <= last_sweep_next;
            idx_reg         <= idx_next;
            rd_pend_reg     <= rd_pend_next;
            spare_found_reg <= spare_found_next;
            m_tvalid_reg    <= m_tvalid_next;
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_addr))
                    CFG_RATE_LIMIT_ENABLE:   cfg_en_reg    <= cfg_wr_data[0];
                    CFG_REQUESTS_PER_SECOND: rps_reg       <= cfg_wr_data;
                    CFG_BURST_LIMIT:         burst_lim_reg <= cfg_wr_data;
                    CFG_SWEEP_INTERVAL:      sweep_int_reg <= cfg_wr_data;
                    default: begin
                        cfg_en_reg <= cfg_en_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        key_reg       <= key_next;
        now_reg       <= now_next;
        rd_idx_reg    <= rd_idx_next;
        spare_idx_reg <= spare_idx_next;
        slot_idx_reg  <= slot_idx_next;
        win_cnt_reg   <= win_cnt_next;
        burst_reg     <= burst_next;
        win_start_reg <= win_start_next;
        last_seen_reg <= last_seen_next;
        verdict_reg   <= verdict_next;
        res_win_reg   <= res_win_next;
        res_burst_reg <= res_burst_next;
        m_tdata_reg   <= m_tdata_next;
    end

`ifndef SYNTHESIS
    // The table is never written while waiting for a request.
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !mem_wr_en)
        else $error("slot memory written while idle");

    // A scan never reads the slot it is writing back in the same cycle.
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("read and write to the same slot in one cycle");

    // A result word appears only out of the result hand-off state.
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("result word raised outside the hand-off state");

    // An accepted request with limiting enabled always checks the sweep first.
    a_accept_to_due: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && cfg_en_reg) |=> (state_reg == S_DUE))
        else $error("enabled request skipped the sweep check");

    // The unused verdict code never leaves the block.
    a_verdict_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[1:0] != 2'd3))
        else $error("undefined verdict code");
`endif

endmodule

// File: sv/pcrl_cmp.sv
// ----------------------------------------------------------------------------
// pcrl_cmp
// Shared compare unit: compares op_a against op_b plus a small offset.
// ----------------------------------------------------------------------------
module pcrl_cmp (
    input  logic [pcrl_pkg::TIME_W-1:0]  op_a,
    input  logic [pcrl_pkg::TIME_W-1:0]  op_b,
    input  logic [pcrl_pkg::COUNT_W-1:0] op_c,
    output pcrl_pkg::cmp_res_t           res
);
    import pcrl_pkg::*;

    logic [TIME_W:0] lhs;
    logic [TIME_W:0] rhs;

    // The offset is added one bit wider so the sum never wraps.
    assign lhs = {1'b0, op_a};
    assign rhs = {1'b0, op_b} + {{(TIME_W + 1 - COUNT_W){1'b0}}, op_c};

    always_comb begin
        res.ge = (lhs >= rhs);
        res.eq = (lhs == rhs);
        res.gt = res.ge & ~res.eq;
    end

endmodule

// File: sv/pcrl_slot_mem.sv
// ----------------------------------------------------------------------------
// pcrl_slot_mem
// Slot table storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module pcrl_slot_mem #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 129,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: bench/per_client_request_rate_limiter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_client_request_rate_limiter_test
// Self-checking bench for the per-client rate limiter. Request words are fed
// through the s_ stream, and a scoreboard with its own copy of the client
// table predicts every verdict word, which is checked on the m_ stream.
// ----------------------------------------------------------------------------
module per_client_request_rate_limiter_test;
    import pcrl_pkg::*;

    localparam int SLOT_COUNT   = DEFAULT_TABLE_ENTRIES;
    localparam int IDLE_PERCENT = 8;
    localparam int TAIL_CYCLES  = 2 * SLOT_COUNT + 20;
    localparam int RUN_LIMIT_NS = 30_000_000;
    localparam int FLOOD_COUNT  = SLOT_COUNT + 6;
    localparam logic [31:0] FLOOD_BASE = 32'hC0A8_0000;

    // One verdict word as the block should send it.
    typedef struct packed {
        verdict_t    verdict;
        logic [15:0] window_requests;
        logic [15:0] burst_used;
    } verdict_rec_t;

    // Predicts verdicts from its own client table and checks the block's words.
    class rate_scoreboard;
        bit          limit_on;
        bit [15:0]   per_second_cap;
        bit [15:0]   burst_cap;
        bit [15:0]   sweep_gap;
        bit          slot_live   [SLOT_COUNT];
        bit [31:0]   slot_client [SLOT_COUNT];
        bit [15:0]   slot_window [SLOT_COUNT];
        bit [15:0]   slot_burst  [SLOT_COUNT];
        bit [31:0]   slot_start  [SLOT_COUNT];
        bit [31:0]   slot_seen   [SLOT_COUNT];
        bit [31:0]   last_sweep;
        verdict_rec_t owed_verdicts [$];
        int unsigned mismatches;
        int unsigned requests_seen, words_checked;
        int unsigned allowed_seen, over_rate_seen, full_seen, bypass_seen;
        int unsigned sweeps_run, slots_expired;

        function new();
            limit_on       = RST_RATE_LIMIT_ENABLE;
            per_second_cap = RST_REQUESTS_PER_SECOND;
            burst_cap      = RST_BURST_LIMIT;
            sweep_gap      = RST_SWEEP_INTERVAL;
            last_sweep     = '0;
            foreach (slot_live[i]) slot_live[i] = 1'b0;
        endfunction

        function int pending();
            return owed_verdicts.size();
        endfunction

        function void write_register(cfg_index_t idx, logic [15:0] value);
            case (idx)
                CFG_RATE_LIMIT_ENABLE:   limit_on       = value[0];
                CFG_REQUESTS_PER_SECOND: per_second_cap = value;
                CFG_BURST_LIMIT:         burst_cap      = value;
                CFG_SWEEP_INTERVAL:      sweep_gap      = value;
                default: ;
            endcase
        endfunction

        // Works out the verdict of one accepted request and queues it.
        function void note_request(logic [31:0] client, logic [31:0] stamp);
            verdict_rec_t want;
            int hit;
            int spare;
            want = '{VERDICT_ALLOW, 16'd0, 16'd0};
            hit = -1;
            spare = -1;
            requests_seen++;
            if (!limit_on) begin
                bypass_seen++;
            end else begin
                // Expiry sweep, skipped when time has gone backwards.
                if (stamp >= last_sweep && stamp - last_sweep >= {16'd0, sweep_gap}) begin
                    last_sweep = stamp;
                    sweeps_run++;
                    foreach (slot_live[i]) begin
                        if (slot_live[i] && stamp > slot_seen[i] &&
                            stamp - slot_seen[i] > {16'd0, IDLE_EXPIRY_SECONDS}) begin
                            slot_live[i] = 1'b0;
                            slots_expired++;
                        end
                    end
                end
                // Keys are unique, so a match anywhere is the client's slot.
                foreach (slot_live[i]) begin
                    if (slot_live[i]) begin
                        if (slot_client[i] == client && hit < 0) hit = i;
                    end else if (spare < 0) begin
                        spare = i;
                    end
                end
                if (hit < 0 && spare >= 0) begin
                    hit = spare;
                    slot_live[hit]   = 1'b1;
                    slot_client[hit] = client;
                    slot_window[hit] = '0;
                    slot_burst[hit]  = '0;
                    slot_start[hit]  = stamp;
                    slot_seen[hit]   = stamp;
                end
                if (hit < 0) begin
                    want.verdict = VERDICT_TABLE_FULL;
                    full_seen++;
                end else begin
                    if (stamp > slot_start[hit]) begin
                        slot_window[hit] = '0;
                        slot_start[hit]  = stamp;
                    end
                    if (slot_window[hit] >= per_second_cap && slot_burst[hit] >= burst_cap) begin
                        want.verdict = VERDICT_OVER_RATE;
                        over_rate_seen++;
                    end else begin
                        if (slot_window[hit] >= per_second_cap && slot_burst[hit] != COUNT_MAX)
                            slot_burst[hit]++;
                        if (slot_window[hit] != COUNT_MAX) slot_window[hit]++;
                        slot_seen[hit] = stamp;
                        allowed_seen++;
                    end
                    want.window_requests = slot_window[hit];
                    want.burst_used      = slot_burst[hit];
                end
            end
            owed_verdicts.push_back(want);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t ns: %s", $time, what);
            mismatches++;
        endtask

        // Compares one accepted verdict word with the oldest prediction.
        task check_verdict(logic [39:0] word);
            verdict_rec_t want;
            if (owed_verdicts.size() == 0) begin
                report_mismatch($sformatf("verdict word %h with none expected", word));
                return;
            end
            want = owed_verdicts.pop_front();
            words_checked++;
            if (word[1:0] !== want.verdict)
                report_mismatch($sformatf("word %0d verdict %0d, expected %s",
                    words_checked, word[1:0], want.verdict.name()));
            if (word[17:2] !== want.window_requests)
                report_mismatch($sformatf("word %0d window_requests %0d, expected %0d",
                    words_checked, word[17:2], want.window_requests));
            if (word[33:18] !== want.burst_used)
                report_mismatch($sformatf("word %0d burst_used %0d, expected %0d",
                    words_checked, word[33:18], want.burst_used));
            if (word[39:34] !== '0)
                report_mismatch($sformatf("word %0d fill bits %b not zero",
                    words_checked, word[39:34]));
        endtask
    endclass

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata     = '0;   // client_addr, now_seconds
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [39:0]           m_tdata;            // verdict, window_requests,
                                               // burst_used, zero fill

    rate_scoreboard board;
    bit             calm = 1'b0;
    logic [31:0]    clock_s = '0;

    // Clock, 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    per_client_request_rate_limiter #(
        .TABLE_ENTRIES (SLOT_COUNT)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Verdict side: check each accepted word, stall at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) board.check_verdict(m_tdata);
            m_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Drives one request word and waits until the block takes it.
    task automatic send_request(input logic [31:0] client, input logic [31:0] stamp);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, client};
        do @(posedge aclk); while (!s_tready);
        board.note_request(client, stamp);
    endtask

    // Stops sending and waits until every predicted verdict has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic put_register(input cfg_index_t idx, input logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        board.write_register(idx, value);
    endtask

    // Writes all four registers on consecutive cycles; only while idle.
    task automatic apply_settings(input logic [15:0] enable_word, input logic [15:0] rps,
                                  input logic [15:0] burst, input logic [15:0] sweep);
        put_register(CFG_RATE_LIMIT_ENABLE, enable_word);
        put_register(CFG_REQUESTS_PER_SECOND, rps);
        put_register(CFG_BURST_LIMIT, burst);
        put_register(CFG_SWEEP_INTERVAL, sweep);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly a small pool of repeat clients, with some one-off addresses as noise.
    task automatic run_clients(input int count, input int pool_size, input int max_step);
        logic [31:0] pool [$];
        logic [31:0] client;
        logic [31:0] stamp;
        for (int k = 0; k < pool_size; k++) pool.push_back($urandom);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 85) client = pool[$urandom_range(pool_size - 1)];
            else client = $urandom;
            if ($urandom_range(99) < 30) clock_s += $urandom_range(max_step, 1);
            stamp = clock_s;
            // A few requests carry a slightly older time.
            if ($urandom_range(99) < 5 && clock_s > 3) stamp = clock_s - $urandom_range(3, 1);
            send_request(client, stamp);
        end
    endtask

    initial begin
        board = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: two new clients at the field extremes, one repeat.
        send_request(32'h0000_0000, 32'd0);
        send_request(32'hFFFF_FFFF, 32'd0);
        send_request(32'h0000_0000, 32'd0);

        // Tight limits: burst draw, rejection, a new second, an older time,
        // then a sweep that frees every idle slot.
        wait_drained();
        apply_settings(16'd1, 16'd1, 16'd1, 16'd60);
        send_request(32'hA5A5_5A5A, 32'd100);
        send_request(32'hA5A5_5A5A, 32'd100);
        send_request(32'hA5A5_5A5A, 32'd100);
        send_request(32'hA5A5_5A5A, 32'd101);
        send_request(32'hA5A5_5A5A, 32'd101);
        send_request(32'hA5A5_5A5A, 32'd99);
        send_request(32'h0000_0000, 32'd500);

        // Limiting off; only bit 0 of the enable word counts.
        wait_drained();
        apply_settings(16'hFFFE, 16'd1, 16'd1, 16'd60);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'h0000_0000, 32'h0000_0000);
        send_request(32'h5555_5555, 32'hAAAA_AAAA);
        send_request(32'hAAAA_AAAA, 32'h5555_5555);

        // Zero limits: every request is rejected at once, even the first of a window.
        wait_drained();
        apply_settings(16'd1, 16'd0, 16'd0, 16'd60);
        send_request(32'h0000_0000, 32'd500);
        send_request(32'h1234_5678, 32'd500);

        // Small limits with a short sweep interval.
        wait_drained();
        clock_s = 32'd600;
        apply_settings(16'd1, 16'd3, 16'd5, 16'd10);
        run_clients(60, 4, 2);

        // Widest limits, a sweep on every request not older than the last sweep, long time steps; no idling.
        wait_drained();
        calm = 1'b1;
        apply_settings(16'd1, 16'hFFFF, 16'hFFFF, 16'd0);
        run_clients(50, 6, 200);
        wait_drained();
        calm = 1'b0;

        // Fill the table with new clients until it reports full.
        apply_settings(16'd1, 16'd2, 16'd1, 16'hFFFF);
        clock_s += 32'd5;
        for (int k = 0; k < FLOOD_COUNT; k++) begin
            if (k % 10 == 9) send_request(FLOOD_BASE + $urandom_range(k), clock_s);
            else send_request(FLOOD_BASE + k, clock_s);
        end

        // Long silence, then a sweep that expires the flooded slots.
        wait_drained();
        clock_s += 32'd400;
        apply_settings(16'd1, 16'd1, 16'd2, 16'd1);
        run_clients(40, 5, 3);

        // Times near the top of the 32-bit range.
        wait_drained();
        clock_s = 32'hFFFF_FF00;
        apply_settings(16'd1, 16'd2, 16'd3, 16'd120);
        run_clients(30, 4, 3);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Covered %0d requests: %0d allowed, %0d over rate, %0d table full, %0d bypassed.",
                 board.requests_seen, board.allowed_seen, board.over_rate_seen,
                 board.full_seen, board.bypass_seen);
        $display("Expiry sweeps run: %0d, slots expired: %0d, words checked: %0d.",
                 board.sweeps_run, board.slots_expired, board.words_checked);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("per_client_request_rate_limiter regression: pass");
        end else begin
            $display("per_client_request_rate_limiter regression: fail");
        end
        $finish;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Run limit reached with %0d verdicts outstanding.", board.pending());
        $display("per_client_request_rate_limiter regression: fail");
        $finish;
    end

endmodule
